[design/slld_pkg.sv]
package slld_pkg;

   localparam logic [15:0] TOL_RESET  = 16'd20;
   localparam logic [2:0]  FLUCT_MAX  = 3'd5;
   localparam int          STEP_W     = 6;
   localparam logic [STEP_W-1:0] SQ_STEPS   = 6'd34;
   localparam logic [STEP_W-1:0] DIV_STEPS  = 6'd45;
   localparam logic [STEP_W-1:0] ROOT_STEPS = 6'd23;
   localparam logic [22:0] DIST_SAT   = 23'h1FFFFF;

   typedef enum logic [1:0] {
      RD_FIRST,
      RD_LAST,
      RD_IDX
   } rd_sel_type;

   typedef struct packed {
      logic       store;
      logic       cnt_clr;
      logic       rd_en;
      rd_sel_type rd_sel;
      logic       ld_first;
      logic       ld_last;
      logic       ld_pt;
      logic       idx_init;
      logic       idx_adv;
      logic       judge_init;
      logic       sq_init;
      logic       sq_step;
      logic       div_init;
      logic       div_step;
      logic       root_init;
      logic       root_src_m;
      logic       root_step;
      logic       judge_upd;
   } cmd_type;

   typedef struct packed {
      logic n_lt2;
      logic n_eq2;
      logic more;
      logic on_seg;
      logic fail;
      logic few_fluct;
   } stat_type;

endpackage

[design/slld_ctrl.sv]
module slld_ctrl
   import slld_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  logic     req_last_point,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   output logic     rsp_is_line,
   output cmd_type  cmd,
   input  stat_type stat
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_START,
      ST_RD_FIRST,
      ST_RD_LAST,
      ST_PT_RD,
      ST_PT_LD,
      ST_MUL,
      ST_SUM,
      ST_EVAL,
      ST_SQ,
      ST_DIV_INIT,
      ST_DIV,
      ST_ROOT_INIT,
      ST_ROOT,
      ST_JUDGE,
      ST_OUT
   } state_type;

   state_type         state_ff;
   logic [STEP_W-1:0] step_ff;
   logic              res_ff;
   logic              rsp_valid_ff;
   logic              rsp_is_line_ff;
   logic              out_free;

   assign req_ready   = (state_ff == ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_is_line = rsp_is_line_ff;
   assign out_free    = !rsp_valid_ff || rsp_ready;

   always_comb begin
      cmd        = '0;
      cmd.rd_sel = RD_FIRST;
      case (state_ff)
         ST_IDLE: begin
            cmd.store = req_valid;
         end
         ST_START: begin
            if (!stat.n_lt2 && !stat.n_eq2) begin
               cmd.rd_en = 1'b1;
            end
         end
         ST_RD_FIRST: begin
            cmd.ld_first = 1'b1;
            cmd.rd_en    = 1'b1;
            cmd.rd_sel   = RD_LAST;
         end
         ST_RD_LAST: begin
            cmd.ld_last    = 1'b1;
            cmd.idx_init   = 1'b1;
            cmd.judge_init = 1'b1;
         end
         ST_PT_RD: begin
            cmd.rd_en  = stat.more;
            cmd.rd_sel = RD_IDX;
         end
         ST_PT_LD: begin
            cmd.ld_pt = 1'b1;
         end
         ST_EVAL: begin
            cmd.sq_init    = stat.on_seg;
            cmd.root_init  = !stat.on_seg;
            cmd.root_src_m = 1'b1;
         end
         ST_SQ: begin
            cmd.sq_step = 1'b1;
         end
         ST_DIV_INIT: begin
            cmd.div_init = 1'b1;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
         end
         ST_ROOT_INIT: begin
            cmd.root_init = 1'b1;
         end
         ST_ROOT: begin
            cmd.root_step = 1'b1;
         end
         ST_JUDGE: begin
            cmd.judge_upd = 1'b1;
            cmd.idx_adv   = !stat.fail;
         end
         ST_OUT: begin
            cmd.cnt_clr = out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         step_ff        <= '0;
         res_ff         <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         rsp_is_line_ff <= 1'b0;
      end else begin
         if (state_ff == ST_OUT && out_free) begin
            rsp_valid_ff   <= 1'b1;
            rsp_is_line_ff <= res_ff;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_valid && req_last_point) begin
                  state_ff <= ST_START;
               end
            end
            ST_START: begin
               if (stat.n_lt2) begin
                  res_ff   <= 1'b0;
                  state_ff <= ST_OUT;
               end else if (stat.n_eq2) begin
                  res_ff   <= 1'b1;
                  state_ff <= ST_OUT;
               end else begin
                  state_ff <= ST_RD_FIRST;
               end
            end
            ST_RD_FIRST: state_ff <= ST_RD_LAST;
            ST_RD_LAST:  state_ff <= ST_PT_RD;
            ST_PT_RD: begin
               if (stat.more) begin
                  state_ff <= ST_PT_LD;
               end else begin
                  res_ff   <= stat.few_fluct;
                  state_ff <= ST_OUT;
               end
            end
            ST_PT_LD: state_ff <= ST_MUL;
            ST_MUL:   state_ff <= ST_SUM;
            ST_SUM:   state_ff <= ST_EVAL;
            ST_EVAL: begin
               step_ff  <= '0;
               state_ff <= stat.on_seg ? ST_SQ : ST_ROOT;
            end
            ST_SQ: begin
               if (step_ff == SQ_STEPS - 1'b1) begin
                  step_ff  <= '0;
                  state_ff <= ST_DIV_INIT;
               end else begin
                  step_ff <= step_ff + 1'b1;
               end
            end
            ST_DIV_INIT: state_ff <= ST_DIV;
            ST_DIV: begin
               if (step_ff == DIV_STEPS - 1'b1) begin
                  step_ff  <= '0;
                  state_ff <= ST_ROOT_INIT;
               end else begin
                  step_ff <= step_ff + 1'b1;
               end
            end
            ST_ROOT_INIT: state_ff <= ST_ROOT;
            ST_ROOT: begin
               if (step_ff == ROOT_STEPS - 1'b1) begin
                  step_ff  <= '0;
                  state_ff <= ST_JUDGE;
               end else begin
                  step_ff <= step_ff + 1'b1;
               end
            end
            ST_JUDGE: begin
               if (stat.fail) begin
                  res_ff   <= 1'b0;
                  state_ff <= ST_OUT;
               end else begin
                  state_ff <= ST_PT_RD;
               end
            end
            ST_OUT: begin
               if (out_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

[design/slld_dp.sv]
module slld_dp
   import slld_pkg::*;
#(
   parameter int MAX_POINTS = 1024
) (
   input  logic               clock,
   input  logic               reset,
   input  logic signed [15:0] req_point_x,
   input  logic signed [15:0] req_point_y,
   input  logic               csr_wr_en,
   input  logic        [15:0] csr_wr_data,
   input  cmd_type            cmd,
   output stat_type           stat
);

   localparam int AW = $clog2(MAX_POINTS);
   localparam int CW = $clog2(MAX_POINTS + 1);
   localparam int IW = CW + 1;
   localparam logic [CW-1:0] MAXC = CW'(MAX_POINTS);

   typedef enum logic [1:0] {
      TR_NONE,
      TR_RISE,
      TR_FALL
   } trend_type;

   logic [31:0]    store_mem [MAX_POINTS];
   logic [31:0]    rdata_ff;
   logic [CW-1:0]  count_ff;
   logic [IW-1:0]  idx_ff;
   logic [15:0]    tolerance_ff;
   logic [AW-1:0]  slot;
   logic [AW-1:0]  rd_addr;

   logic signed [15:0] x1_ff, y1_ff, x2_ff, y2_ff;
   logic signed [15:0] rx, ry;
   logic signed [16:0] dx, dy;
   logic signed [16:0] px_ff, py_ff, qx_ff, qy_ff;

   logic signed [33:0] p_dxdx_ff, p_dydy_ff, p_dxpx_ff, p_dypy_ff, p_dxpy_ff, p_dypx_ff;
   logic signed [33:0] p_pxpx_ff, p_pypy_ff, p_qxqx_ff, p_qyqy_ff;

   logic        [33:0] len2_ff, m1_ff, m2_ff;
   logic signed [34:0] dot_ff, cr_ff;
   logic signed [34:0] cr_neg;
   logic        [33:0] c_abs;
   logic        [33:0] m_min;

   logic [67:0] sq_mc_ff;
   logic [33:0] sq_mp_ff;
   logic [67:0] sq_acc_ff;

   logic [34:0] div_rem_ff;
   logic [44:0] div_num_ff;
   logic [34:0] div_trial;
   logic        div_ge;

   logic [45:0] rt_v_ff;
   logic [24:0] rt_rem_ff;
   logic [22:0] rt_root_ff;
   logic [26:0] rt_cur;
   logic [26:0] rt_trial;
   logic        in_seg_ff;

   logic [22:0] dist_q;
   logic [22:0] last_ff;
   logic [22:0] lim;
   logic [22:0] diff_up, diff_dn;
   logic [25:0] six_up, six_dn;
   trend_type   trend_ff;
   logic [2:0]  fluct_ff;
   logic        big_up, big_dn;

   assign slot = (count_ff < MAXC) ? count_ff[AW-1:0] : AW'(MAX_POINTS - 1);

   always_comb begin
      case (cmd.rd_sel)
         RD_FIRST: rd_addr = '0;
         RD_LAST:  rd_addr = AW'(count_ff - CW'(1));
         RD_IDX:   rd_addr = idx_ff[AW-1:0];
         default:  rd_addr = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.store) begin
         store_mem[slot] <= {req_point_y, req_point_x};
      end
      if (cmd.rd_en) begin
         rdata_ff <= store_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         tolerance_ff <= TOL_RESET;
      end else begin
         if (csr_wr_en) begin
            tolerance_ff <= csr_wr_data;
         end
         if (cmd.cnt_clr) begin
            count_ff <= '0;
         end else if (cmd.store && count_ff < MAXC) begin
            count_ff <= count_ff + 1'b1;
         end
      end
   end

   assign rx = rdata_ff[15:0];
   assign ry = rdata_ff[31:16];
   assign dx = 17'(x2_ff) - 17'(x1_ff);
   assign dy = 17'(y2_ff) - 17'(y1_ff);

   always_ff @(posedge clock) begin
      if (cmd.ld_first) begin
         x1_ff <= rx;
         y1_ff <= ry;
      end
      if (cmd.ld_last) begin
         x2_ff <= rx;
         y2_ff <= ry;
      end
      if (cmd.ld_pt) begin
         px_ff <= 17'(rx) - 17'(x1_ff);
         py_ff <= 17'(ry) - 17'(y1_ff);
         qx_ff <= 17'(rx) - 17'(x2_ff);
         qy_ff <= 17'(ry) - 17'(y2_ff);
      end
      if (cmd.idx_init) begin
         idx_ff <= IW'(1);
      end else if (cmd.idx_adv) begin
         idx_ff <= idx_ff + IW'(2);
      end
   end

   // product and sum stages
   always_ff @(posedge clock) begin
      p_dxdx_ff <= 34'(dx) * 34'(dx);
      p_dydy_ff <= 34'(dy) * 34'(dy);
      p_dxpx_ff <= 34'(dx) * 34'(px_ff);
      p_dypy_ff <= 34'(dy) * 34'(py_ff);
      p_dxpy_ff <= 34'(dx) * 34'(py_ff);
      p_dypx_ff <= 34'(dy) * 34'(px_ff);
      p_pxpx_ff <= 34'(px_ff) * 34'(px_ff);
      p_pypy_ff <= 34'(py_ff) * 34'(py_ff);
      p_qxqx_ff <= 34'(qx_ff) * 34'(qx_ff);
      p_qyqy_ff <= 34'(qy_ff) * 34'(qy_ff);
      len2_ff   <= 34'($unsigned(p_dxdx_ff)) + 34'($unsigned(p_dydy_ff));
      m1_ff     <= 34'($unsigned(p_pxpx_ff)) + 34'($unsigned(p_pypy_ff));
      m2_ff     <= 34'($unsigned(p_qxqx_ff)) + 34'($unsigned(p_qyqy_ff));
      dot_ff    <= 35'(p_dxpx_ff) + 35'(p_dypy_ff);
      cr_ff     <= 35'(p_dxpy_ff) - 35'(p_dypx_ff);
   end

   assign cr_neg = -cr_ff;
   assign c_abs  = cr_ff[34] ? cr_neg[33:0] : cr_ff[33:0];
   assign m_min  = (m1_ff < m2_ff) ? m1_ff : m2_ff;

   // serial square of the cross product
   always_ff @(posedge clock) begin
      if (cmd.sq_init) begin
         sq_mc_ff  <= {34'd0, c_abs};
         sq_mp_ff  <= c_abs;
         sq_acc_ff <= '0;
      end else if (cmd.sq_step) begin
         if (sq_mp_ff[0]) begin
            sq_acc_ff <= sq_acc_ff + sq_mc_ff;
         end
         sq_mc_ff <= {sq_mc_ff[66:0], 1'b0};
         sq_mp_ff <= {1'b0, sq_mp_ff[33:1]};
      end
   end

   // restoring divide of 256 * cross^2 by squared chord length
   assign div_trial = {div_rem_ff[33:0], div_num_ff[44]};
   assign div_ge    = div_trial >= {1'b0, len2_ff};

   always_ff @(posedge clock) begin
      if (cmd.div_init) begin
         div_rem_ff <= {4'd0, sq_acc_ff[67:37]};
         div_num_ff <= {sq_acc_ff[36:0], 8'd0};
      end else if (cmd.div_step) begin
         div_rem_ff <= div_ge ? (div_trial - {1'b0, len2_ff}) : div_trial;
         div_num_ff <= {div_num_ff[43:0], div_ge};
      end
   end

   // digit-by-digit square root, two radicand bits per step
   assign rt_cur   = {rt_rem_ff, rt_v_ff[45:44]};
   assign rt_trial = {2'd0, rt_root_ff, 2'b01};

   always_ff @(posedge clock) begin
      if (cmd.root_init) begin
         rt_v_ff    <= cmd.root_src_m ? {4'd0, m_min, 8'd0} : {1'b0, div_num_ff};
         rt_rem_ff  <= '0;
         rt_root_ff <= '0;
         in_seg_ff  <= !cmd.root_src_m;
      end else if (cmd.root_step) begin
         rt_v_ff <= {rt_v_ff[43:0], 2'b00};
         if (rt_cur >= rt_trial) begin
            rt_rem_ff  <= 25'(rt_cur - rt_trial);
            rt_root_ff <= {rt_root_ff[21:0], 1'b1};
         end else begin
            rt_rem_ff  <= rt_cur[24:0];
            rt_root_ff <= {rt_root_ff[21:0], 1'b0};
         end
      end
   end

   assign dist_q  = (in_seg_ff && rt_root_ff > DIST_SAT) ? DIST_SAT : rt_root_ff;
   assign lim     = {3'd0, tolerance_ff, 4'd0};
   assign diff_up = dist_q - last_ff;
   assign diff_dn = last_ff - dist_q;
   assign six_up  = {1'b0, diff_up, 2'b00} + {2'b00, diff_up, 1'b0};
   assign six_dn  = {1'b0, diff_dn, 2'b00} + {2'b00, diff_dn, 1'b0};
   assign big_up  = six_up >= {3'd0, lim};
   assign big_dn  = six_dn >= {3'd0, lim};

   always_ff @(posedge clock) begin
      if (cmd.judge_init) begin
         last_ff  <= '0;
         trend_ff <= TR_NONE;
         fluct_ff <= '0;
      end else if (cmd.judge_upd && !stat.fail) begin
         if (dist_q > last_ff && trend_ff != TR_RISE && big_up) begin
            fluct_ff <= (fluct_ff == 3'd7) ? fluct_ff : fluct_ff + 1'b1;
            trend_ff <= TR_RISE;
            last_ff  <= dist_q;
         end else if (dist_q < last_ff && trend_ff != TR_FALL && big_dn) begin
            fluct_ff <= (fluct_ff == 3'd7) ? fluct_ff : fluct_ff + 1'b1;
            trend_ff <= TR_FALL;
            last_ff  <= dist_q;
         end
      end
   end

   always_comb begin
      stat.n_lt2     = count_ff < CW'(2);
      stat.n_eq2     = count_ff == CW'(2);
      stat.more      = (idx_ff + IW'(1)) < {1'b0, count_ff};
      stat.on_seg    = (len2_ff != '0) && !dot_ff[34] && ($unsigned(dot_ff) <= {1'b0, len2_ff});
      stat.fail      = dist_q > lim;
      stat.few_fluct = fluct_ff <= FLUCT_MAX;
   end

endmodule

[design/stroke_straight_line_detector.sv]
// channel | direction | ports
// req     | in        | req_valid, req_ready, req_point_x, req_point_y, req_last_point
// rsp     | out       | rsp_valid, rsp_ready, rsp_is_line
// csr     | in        | csr_wr_en, csr_wr_data (tolerance)
//
// a point beat takes one cycle; beats are taken back to back while no stroke is judged
// judging walks the odd interior points, each with 23 root steps and a judge state,
// plus 34 square steps, 45 divide steps and their setup states when the foot falls on the chord
// the walk is set by the one shared square, divide and root unit and the store's read port
// synchronous active-high reset clears the point count and sets tolerance to 20
// req_ready is low from the last point until the result is in the output register
module stroke_straight_line_detector
   import slld_pkg::*;
#(
   parameter int MAX_POINTS = 1024
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [15:0] req_point_x,
   input  logic signed [15:0] req_point_y,
   input  logic               req_last_point,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_is_line,
   input  logic               csr_wr_en,
   input  logic        [15:0] csr_wr_data
);

   cmd_type  cmd;
   stat_type stat;

   slld_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_last_point (req_last_point),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_is_line    (rsp_is_line),
      .cmd            (cmd),
      .stat           (stat)
   );

   slld_dp #(
      .MAX_POINTS (MAX_POINTS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_point_x (req_point_x),
      .req_point_y (req_point_y),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .stat        (stat)
   );

   a_last_stalls: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_last_point) |=> !req_ready)
      else $error("input still open after last point");

   a_result_idle: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> req_ready)
      else $error("result shown while still judging");

   a_one_unit: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.sq_step, cmd.div_step, cmd.root_step, cmd.store}))
      else $error("arithmetic steps overlap");

endmodule
